@@ rtl/tad_pkg.sv @@
// Shared constants, register codes and state type for the temperature average unit.
package tad_pkg;

    localparam int ADC_BITS      = 12;
    localparam int FRACTION_BITS = 16;
    localparam int DIGITS        = 6;

    localparam int WHOLE_BITS    = 7;
    localparam int AVG_BITS      = FRACTION_BITS + WHOLE_BITS;
    localparam int COUNT_BITS    = 7;
    localparam int SCALE_BITS    = 16;
    localparam int DIGIT_FIELDS  = 6;
    localparam int DIGIT_BITS    = 4;
    localparam int DIV_BITS      = COUNT_BITS + 1;

    localparam int MUL_STEPS = (ADC_BITS > COUNT_BITS) ? ADC_BITS : COUNT_BITS;
    localparam int PROD_A    = ADC_BITS + SCALE_BITS;
    localparam int PROD_B    = AVG_BITS + COUNT_BITS;
    localparam int NUM_BITS  = ((PROD_A > PROD_B) ? PROD_A : PROD_B) + 1;
    localparam int STEP_BITS = $clog2((MUL_STEPS > NUM_BITS) ? MUL_STEPS : NUM_BITS);

    localparam int CFG_DATA_BITS = (AVG_BITS > SCALE_BITS) ? AVG_BITS : SCALE_BITS;
    localparam int CFG_INDEX_BITS = 2;

    localparam int IN_FIELD_BITS = 12;
    localparam int IN_TDATA_BITS = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_BITS      = AVG_BITS + WHOLE_BITS + DIGIT_FIELDS * DIGIT_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [SCALE_BITS-1:0] SCALE_RESET    = SCALE_BITS'(1920);
    localparam logic [AVG_BITS-1:0]   INIT_AVG_RESET = AVG_BITS'(20) << FRACTION_BITS;
    localparam logic [COUNT_BITS-1:0] WRAP_RESET     = COUNT_BITS'(100);
    localparam logic [COUNT_BITS-1:0] RESTART_RESET  = COUNT_BITS'(10);
    localparam logic [COUNT_BITS-1:0] COUNT_RESET    = COUNT_BITS'(1);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_SCALE    = 2'd0,
        REG_INIT_AVG = 2'd1,
        REG_WRAP     = 2'd2,
        REG_RESTART  = 2'd3
    } tad_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_SAT,
        ST_BCD,
        ST_HOLD
    } tad_state_t;

endpackage

@@ rtl/tad_bcd.sv @@
// Bit-serial binary to decimal converter (shift and add three) for the whole degrees.
module tad_bcd #(
    parameter int DIGITS = tad_pkg::DIGITS
) (
    input  logic                                                aclk,
    input  logic                                                aresetn,
    input  logic                                                start,
    input  logic [tad_pkg::WHOLE_BITS-1:0]                      value,
    output logic                                                done,
    output logic [tad_pkg::DIGIT_FIELDS*tad_pkg::DIGIT_BITS-1:0] digits
);
    import tad_pkg::*;

    localparam int LIVE = (DIGITS < DIGIT_FIELDS) ? DIGITS : DIGIT_FIELDS;
    localparam int W    = DIGIT_FIELDS * DIGIT_BITS;
    localparam int SB   = (WHOLE_BITS > 1) ? $clog2(WHOLE_BITS) : 1;

    logic [WHOLE_BITS-1:0] val_reg, val_next;
    logic [W-1:0]          bcd_reg, bcd_next;
    logic [SB-1:0]         step_reg, step_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [W-1:0]          adj;
    logic [W-1:0]          shifted;

    always_comb begin
        adj = bcd_reg;
        for (int d = 0; d < DIGIT_FIELDS; d++) begin
            if (d < LIVE && adj[d*DIGIT_BITS +: DIGIT_BITS] >= DIGIT_BITS'(5)) begin
                adj[d*DIGIT_BITS +: DIGIT_BITS] = adj[d*DIGIT_BITS +: DIGIT_BITS] + DIGIT_BITS'(3);
            end
        end
        shifted = {adj[W-2:0], val_reg[WHOLE_BITS-1]};
        for (int d = 0; d < DIGIT_FIELDS; d++) begin
            if (d >= LIVE) begin
                shifted[d*DIGIT_BITS +: DIGIT_BITS] = '0;
            end
        end
    end

    always_comb begin
        val_next  = val_reg;
        bcd_next  = bcd_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            val_next  = value;
            bcd_next  = '0;
            step_next = SB'(WHOLE_BITS - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            val_next = {val_reg[WHOLE_BITS-2:0], 1'b0};
            bcd_next = shifted;
            if (step_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                step_next = step_reg - SB'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        val_reg  <= val_next;
        bcd_reg  <= bcd_next;
        step_reg <= step_next;
    end

    assign done   = done_reg;
    assign digits = bcd_reg;

endmodule

@@ rtl/temperature_average_decimal_unit.sv @@
// Top level of the temperature averaging unit with decimal digit output.
//
// Requests enter on the s_axis channel: s_axis_tdata[11:0] is the raw ADC sample.
// Results leave on the m_axis channel, one per request, packed from bit 0 up as
// average (23 bits, 16 fraction bits), whole degrees (7), then six decimal digits
// of 4 bits each, ones first. Registers are written on the cfg channel (index 0
// scale, 1 initial average, 2 count wrap value, 3 count restart value); cfg_ready
// is always high. Writing the initial average restarts averaging from that value.
// Write registers only while no request is in flight.
//
// Each request passes from acceptance to m_axis_tvalid through bit-serial multiply,
// restoring division one quotient bit a cycle, a saturate step, serial decimal
// conversion and an output load. A new request is taken only once the last one
// has been loaded into the result register, so requests never overlap in the arithmetic.
// The result register lets a new request start while the last result still waits;
// a stalled receiver holds the next result until the register frees.
// Reset clears the channels and loads the average with 20.0 and the count with 1.
module temperature_average_decimal_unit #(
    parameter int DIGITS = tad_pkg::DIGITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [tad_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,   // adc_sample
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // average_fixed, whole_degrees, digit_units, digit_tens, digit_hundreds,
    // digit_thousands, digit_ten_thousands, digit_hundred_thousands
    output logic [tad_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tad_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [tad_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import tad_pkg::*;

    localparam int DW = DIGIT_FIELDS * DIGIT_BITS;

    tad_state_t               state_reg, state_next;
    logic [SCALE_BITS-1:0]    scale_reg;
    logic [COUNT_BITS-1:0]    wrap_reg, restart_reg;
    logic [AVG_BITS-1:0]      avg_reg;
    logic [COUNT_BITS-1:0]    count_reg;
    logic [STEP_BITS-1:0]     step_reg;
    logic [MUL_STEPS-1:0]     sample_sh_reg, cnt_sh_reg;
    logic [NUM_BITS-1:0]      acc_reg;
    logic [COUNT_BITS-1:0]    rem_reg;
    logic                     out_valid_reg;
    logic [OUT_TDATA_BITS-1:0] out_data_reg;

    logic                     s_accept, cfg_accept;
    logic                     step_zero;
    logic [NUM_BITS-1:0]      mul_sum;
    logic [DIV_BITS-1:0]      rem_shift, divisor, rem_diff;
    logic                     rem_ge;
    logic                     overflow;
    logic [AVG_BITS-1:0]      quot;
    logic [COUNT_BITS-1:0]    count_inc, count_new;
    logic                     bcd_start, bcd_done;
    logic [DW-1:0]            digits;
    logic                     out_free;
    logic                     out_load;

    assign s_accept   = s_axis_tvalid && s_axis_tready;
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign step_zero  = (step_reg == '0);
    assign out_free   = !out_valid_reg || m_axis_tready;

    assign mul_sum = {acc_reg[NUM_BITS-2:0], 1'b0}
                   + (sample_sh_reg[MUL_STEPS-1] ? NUM_BITS'(scale_reg) : '0)
                   + (cnt_sh_reg[MUL_STEPS-1]    ? NUM_BITS'(avg_reg)   : '0);

    assign rem_shift = {rem_reg, acc_reg[NUM_BITS-1]};
    assign divisor   = DIV_BITS'(count_reg) + DIV_BITS'(1);
    assign rem_ge    = (rem_shift >= divisor);
    assign rem_diff  = rem_shift - divisor;

    assign overflow  = |acc_reg[NUM_BITS-1:AVG_BITS];
    assign quot      = overflow ? '1 : acc_reg[AVG_BITS-1:0];
    assign count_inc = count_reg + COUNT_BITS'(1);
    assign count_new = (count_inc == wrap_reg) ? restart_reg : count_inc;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_accept)     state_next = ST_MUL;
            ST_MUL:  if (step_zero)    state_next = ST_DIV;
            ST_DIV:  if (step_zero)    state_next = ST_SAT;
            ST_SAT:                    state_next = ST_BCD;
            ST_BCD:  if (bcd_done)     state_next = ST_HOLD;
            ST_HOLD: if (out_free)     state_next = ST_IDLE;
            default:                   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        bcd_start     = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_SAT:  bcd_start     = 1'b1;
            ST_HOLD: out_load      = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            scale_reg     <= SCALE_RESET;
            wrap_reg      <= WRAP_RESET;
            restart_reg   <= RESTART_RESET;
            avg_reg       <= INIT_AVG_RESET;
            count_reg     <= COUNT_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_accept) begin
                case (cfg_index)
                    REG_SCALE:    scale_reg <= cfg_data[SCALE_BITS-1:0];
                    REG_INIT_AVG: begin
                        avg_reg   <= cfg_data[AVG_BITS-1:0];
                        count_reg <= COUNT_RESET;
                    end
                    REG_WRAP:     wrap_reg    <= cfg_data[COUNT_BITS-1:0];
                    REG_RESTART:  restart_reg <= cfg_data[COUNT_BITS-1:0];
                    default: ;
                endcase
            end else if (state_reg == ST_SAT) begin
                avg_reg   <= quot;
                count_reg <= count_new;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                sample_sh_reg <= MUL_STEPS'(s_axis_tdata[ADC_BITS-1:0]);
                cnt_sh_reg    <= MUL_STEPS'(count_reg);
                acc_reg       <= '0;
                rem_reg       <= '0;
                step_reg      <= STEP_BITS'(MUL_STEPS - 1);
            end
            ST_MUL: begin
                sample_sh_reg <= {sample_sh_reg[MUL_STEPS-2:0], 1'b0};
                cnt_sh_reg    <= {cnt_sh_reg[MUL_STEPS-2:0], 1'b0};
                acc_reg       <= mul_sum;
                step_reg      <= step_zero ? STEP_BITS'(NUM_BITS - 1) : step_reg - STEP_BITS'(1);
            end
            ST_DIV: begin
                acc_reg  <= {acc_reg[NUM_BITS-2:0], rem_ge};
                rem_reg  <= rem_ge ? rem_diff[COUNT_BITS-1:0] : rem_shift[COUNT_BITS-1:0];
                step_reg <= step_reg - STEP_BITS'(1);
            end
            default: ;
        endcase
        if (out_load) begin
            out_data_reg <= OUT_TDATA_BITS'({digits, avg_reg[AVG_BITS-1:FRACTION_BITS], avg_reg});
        end
    end

    tad_bcd #(
        .DIGITS (DIGITS)
    ) u_bcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (bcd_start),
        .value   (quot[AVG_BITS-1:FRACTION_BITS]),
        .done    (bcd_done),
        .digits  (digits)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    a_accept_starts_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> state_reg == ST_MUL)
        else $error("accepted request did not start the multiply");

    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> DIV_BITS'(rem_reg) < divisor)
        else $error("division remainder not below divisor");

    a_bcd_done_in_bcd: assert property (@(posedge aclk) disable iff (!aresetn)
        bcd_done |-> state_reg == ST_BCD)
        else $error("decimal conversion finished outside its state");

    a_load_needs_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_axis_tvalid)
        else $error("result load did not raise tvalid");

endmodule
